// ----- rtl/ps2_mouse_packet_tracker_defines.svh -----
// Assertion macros shared by the mouse packet tracker RTL.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`ifndef SYNTH
`define PS2MT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ps2mt assertion failed (same cycle)");
`define PS2MT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ps2mt assertion failed (next cycle)");
`else
`define PS2MT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PS2MT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ps2mt_pkg.sv -----
// Types and constants of the mouse packet tracker.
package ps2mt_pkg;

	localparam int POS_W = 15;
	localparam int SPEED_W = 10;
	localparam int DROP_W = 32;

	localparam logic [POS_W-1:0] POSITION_MAX = 15'd32767;
	localparam logic [POS_W-1:0] POS_RESET = POSITION_MAX / 2;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd32;
	localparam logic [SPEED_W-1:0] SPEED_LIMIT = 10'd512;

	// header byte bit positions
	localparam int HDR_LEFT = 0;
	localparam int HDR_RIGHT = 1;
	localparam int HDR_SYNC = 3;
	localparam int HDR_XSIGN = 4;
	localparam int HDR_YSIGN = 5;
	localparam int HDR_XOVF = 6;
	localparam int HDR_YOVF = 7;

	// which byte of the packet comes next
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_XDATA  = 2'd1,
		PH_YDATA  = 2'd2
	} phase_t;

	// one axis of movement as carried in the packet
	typedef struct packed {
		logic [7:0] data;
		logic       neg;
		logic       ovf;
	} delta_t;

endpackage

// ----- rtl/ps2mt_axis.sv -----
// One axis of position update: scale the delta, add or subtract, clamp.
module ps2mt_axis (
	input  logic [ps2mt_pkg::POS_W-1:0]   pos,
	input  ps2mt_pkg::delta_t             delta,
	input  logic [ps2mt_pkg::SPEED_W-1:0] scale,
	input  logic                          sub,
	output logic [ps2mt_pkg::POS_W-1:0]   new_pos,
	output logic                          moved
);

	logic signed [8:0]  dval;
	logic signed [10:0] sc_s;
	logic signed [19:0] prod;
	logic signed [20:0] pos_ext;
	logic signed [20:0] sum;

	assign dval = delta.ovf ? 9'sd0 : $signed({delta.neg, delta.data});
	assign sc_s = $signed({1'b0, scale});
	assign prod = 20'(dval) * 20'(sc_s);
	assign pos_ext = $signed({6'b0, pos});
	assign sum = sub ? (pos_ext - 21'(prod)) : (pos_ext + 21'(prod));
	assign moved = (dval != 9'sd0);

	always_comb begin
		if (sum[20]) begin
			new_pos = '0;
		end else if (sum > $signed({6'b0, ps2mt_pkg::POSITION_MAX})) begin
			new_pos = ps2mt_pkg::POSITION_MAX;
		end else begin
			new_pos = sum[ps2mt_pkg::POS_W-1:0];
		end
	end

endmodule

// ----- rtl/ps2_mouse_packet_tracker.sv -----
// PS/2 mouse packet tracker: frames aux bytes into packets and keeps a position.
//
// Takes one raw auxiliary byte per input word and returns exactly one output
// word per byte. While no packet is open, a byte is taken as a header only if
// bit 3 is set and both overflow bits are clear; any other byte is dropped and
// counted in a 32-bit saturating counter. The next two bytes are the X and Y
// deltas, taken without checks. On the third byte the 9-bit signed deltas
// (zero where the overflow bit is set) are multiplied by speed_scale and added
// to the absolute position (Y subtracted, so down is positive), both axes
// clamped to 0..32767; left and right buttons are latched. Positions start at
// 16383, speed_scale at 32. A speed write of zero is ignored and values above
// 512 store 512; write it only while no word is in flight. Throughput is one
// byte per clock unless m_tready stalls the output; a byte passes the input
// register, then the result register. The cycle is set by the position feedback
// path through the 9x11 multiply, add and clamp. The result register lets a new
// byte enter while a finished word still waits on m_tready.
//
// m_tdata, from bit 0 up: pos_x[14:0], pos_y[29:15], button_bits[31:30],
// drop_total[63:32]. m_tuser, from bit 0 up: packet_done, state_changed,
// byte_dropped.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2_mouse_packet_tracker (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: speed_scale
	input  logic        speed_we,
	input  logic [9:0]  speed_wdata,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // aux_byte_in[7:0]
	// output words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pos_x, pos_y, button_bits, drop_total
	output logic [2:0]  m_tuser    // packet_done, state_changed, byte_dropped
);

	localparam int PW = ps2mt_pkg::POS_W;
	localparam int DW = ps2mt_pkg::DROP_W;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic        valid_s2;
	logic [63:0] data_s2;
	logic [2:0]  user_s2;

	// tracker state
	ps2mt_pkg::phase_t                phase_q, phase_d;
	logic [7:0]                       hdr_q;
	logic [7:0]                       xbyte_q;
	logic [PW-1:0]                    pos_x_q, pos_y_q;
	logic [1:0]                       btn_q;
	logic [DW-1:0]                    drop_q;
	logic [ps2mt_pkg::SPEED_W-1:0]    speed_q;

	// next values
	logic          advance;
	logic          hdr_ok;
	logic          done, changed, dropped;
	logic [PW-1:0] pos_x_d, pos_y_d;
	logic [1:0]    btn_d;
	logic [DW-1:0] drop_d;

	ps2mt_pkg::delta_t dx, dy;
	logic [PW-1:0]     ax_x_pos, ax_y_pos;
	logic              ax_x_moved, ax_y_moved;

	// move a byte into the update stage when the result register is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = user_s2;

	assign hdr_ok = byte_s1[ps2mt_pkg::HDR_SYNC] && !byte_s1[ps2mt_pkg::HDR_XOVF]
		&& !byte_s1[ps2mt_pkg::HDR_YOVF];

	assign dx = '{data: xbyte_q, neg: hdr_q[ps2mt_pkg::HDR_XSIGN],
		ovf: hdr_q[ps2mt_pkg::HDR_XOVF]};
	assign dy = '{data: byte_s1, neg: hdr_q[ps2mt_pkg::HDR_YSIGN],
		ovf: hdr_q[ps2mt_pkg::HDR_YOVF]};

	ps2mt_axis u_axis_x (
		.pos     (pos_x_q),
		.delta   (dx),
		.scale   (speed_q),
		.sub     (1'b0),
		.new_pos (ax_x_pos),
		.moved   (ax_x_moved)
	);

	ps2mt_axis u_axis_y (
		.pos     (pos_y_q),
		.delta   (dy),
		.scale   (speed_q),
		.sub     (1'b1),
		.new_pos (ax_y_pos),
		.moved   (ax_y_moved)
	);

	// packet framing: next phase
	always_comb begin
		unique case (phase_q)
			ps2mt_pkg::PH_HEADER: begin
				phase_d = hdr_ok ? ps2mt_pkg::PH_XDATA : ps2mt_pkg::PH_HEADER;
			end
			ps2mt_pkg::PH_XDATA: begin
				phase_d = ps2mt_pkg::PH_YDATA;
			end
			ps2mt_pkg::PH_YDATA: begin
				phase_d = ps2mt_pkg::PH_HEADER;
			end
			default: begin
				phase_d = ps2mt_pkg::PH_HEADER;
			end
		endcase
	end

	// per-phase results and state updates
	always_comb begin
		done    = 1'b0;
		changed = 1'b0;
		dropped = 1'b0;
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		btn_d   = btn_q;
		drop_d  = drop_q;
		unique case (phase_q)
			ps2mt_pkg::PH_HEADER: begin
				if (!hdr_ok) begin
					dropped = 1'b1;
					if (drop_q != '1) begin
						drop_d = drop_q + 1'b1;
					end
				end
			end
			ps2mt_pkg::PH_XDATA: begin
			end
			ps2mt_pkg::PH_YDATA: begin
				done    = 1'b1;
				pos_x_d = ax_x_pos;
				pos_y_d = ax_y_pos;
				btn_d   = {hdr_q[ps2mt_pkg::HDR_RIGHT], hdr_q[ps2mt_pkg::HDR_LEFT]};
				changed = ax_x_moved || ax_y_moved || (btn_d != btn_q);
			end
			default: begin
			end
		endcase
	end

	// input register: hold while the update stage is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// tracker state: advance once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ps2mt_pkg::PH_HEADER;
			hdr_q   <= '0;
			xbyte_q <= '0;
			pos_x_q <= ps2mt_pkg::POS_RESET;
			pos_y_q <= ps2mt_pkg::POS_RESET;
			btn_q   <= '0;
			drop_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (phase_q == ps2mt_pkg::PH_HEADER && hdr_ok) begin
				hdr_q <= byte_s1;
			end
			if (phase_q == ps2mt_pkg::PH_XDATA) begin
				xbyte_q <= byte_s1;
			end
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
			btn_q   <= btn_d;
			drop_q  <= drop_d;
		end
	end

	// speed register: drop zero writes, limit to 512
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= ps2mt_pkg::SPEED_RESET;
		end else if (speed_we && speed_wdata != '0) begin
			speed_q <= (speed_wdata > ps2mt_pkg::SPEED_LIMIT) ? ps2mt_pkg::SPEED_LIMIT
				: speed_wdata;
		end
	end

	// result register: load on advance, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {drop_d, btn_d, pos_y_d, pos_x_d};
			user_s2 <= {dropped, changed, done};
		end
	end

	`PS2MT_ASSERT_IMPLY(a_done_xor_drop, clk, arst_n, valid_s2, !(user_s2[0] && user_s2[2]))
	`PS2MT_ASSERT_IMPLY(a_change_needs_done, clk, arst_n, valid_s2 && user_s2[1], user_s2[0])
	`PS2MT_ASSERT_NEXT(a_drop_monotonic, clk, arst_n, advance, drop_q >= $past(drop_q))
	`PS2MT_ASSERT_IMPLY(a_speed_range, clk, arst_n, 1'b1,
		speed_q != '0 && speed_q <= ps2mt_pkg::SPEED_LIMIT)

endmodule

// ----- tb/tb_ps2_mouse_packet_tracker.sv -----
// Self-checking testbench: drives aux bytes into the mouse packet tracker, checks each word.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_tracker;

	// cycles to let pass after the last word before a speed write or the end
	localparam int DRAIN_CYCLES = 4;
	// cycles without any accepted word before the run is declared hung
	localparam int HANG_LIMIT = 3000;
	localparam int RANDOM_WORDS = 370;
	localparam int SPW = ps2mt_pkg::SPEED_W;

	// one output word, split into its fields
	typedef struct packed {
		logic [ps2mt_pkg::POS_W-1:0]  pos_x;
		logic [ps2mt_pkg::POS_W-1:0]  pos_y;
		logic [1:0]                   buttons;
		logic                         done;
		logic                         changed;
		logic                         dropped;
		logic [ps2mt_pkg::DROP_W-1:0] drop_total;
	} mouse_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               speed_we = 1'b0;
	logic [SPW-1:0]     speed_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;   // aux_byte_in[7:0]
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [63:0]        m_tdata;        // pos_x[14:0], pos_y[29:15], button_bits[31:30],
	                                    // drop_total[63:32]
	logic [2:0]         m_tuser;        // packet_done, state_changed, byte_dropped

	// idle rates in percent for the byte sender and the word receiver
	int send_idle_pct = 36;
	int recv_idle_pct = 68;
	int fail_count = 0;
	int hang_cycles = 0;

	// tracked copy of the block: speed, packet framing, position, buttons, drops
	logic [SPW-1:0]               speed_scale = ps2mt_pkg::SPEED_RESET;
	ps2mt_pkg::phase_t            pkt_phase = ps2mt_pkg::PH_HEADER;
	logic [7:0]                   held_header = '0;
	logic [7:0]                   held_x_byte = '0;
	logic [ps2mt_pkg::POS_W-1:0]  track_x = ps2mt_pkg::POS_RESET;
	logic [ps2mt_pkg::POS_W-1:0]  track_y = ps2mt_pkg::POS_RESET;
	logic [1:0]                   track_buttons = '0;
	logic [ps2mt_pkg::DROP_W-1:0] drop_count = '0;

	mouse_word_t pending_words[$];

	// handshakes sampled in the low phase, where every signal is settled
	logic               byte_take = 1'b0;
	logic [7:0]         byte_seen = '0;
	logic               word_take = 1'b0;
	logic [63:0]        word_data = '0;
	logic [2:0]         word_user = '0;
	logic               speed_take = 1'b0;
	logic [SPW-1:0]     speed_seen = '0;

	ps2_mouse_packet_tracker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.speed_we    (speed_we),
		.speed_wdata (speed_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stall the output side at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(negedge clk) begin
		byte_take = (s_tvalid === 1'b1) && (s_tready === 1'b1);
		byte_seen = s_tdata;
		word_take = (m_tvalid === 1'b1) && (m_tready === 1'b1);
		word_data = m_tdata;
		word_user = m_tuser;
		speed_take = speed_we;
		speed_seen = speed_wdata;
	end

	function automatic logic [ps2mt_pkg::POS_W-1:0] clamp_axis(input int v);
		if (v < 0)
			return '0;
		if (v > int'(ps2mt_pkg::POSITION_MAX))
			return ps2mt_pkg::POSITION_MAX;
		return v[ps2mt_pkg::POS_W-1:0];
	endfunction

	// zero writes leave the speed alone; anything above the limit saturates
	task automatic apply_speed(input logic [SPW-1:0] v);
		if (v != '0)
			speed_scale = (v > ps2mt_pkg::SPEED_LIMIT) ? ps2mt_pkg::SPEED_LIMIT : v;
	endtask

	// advance the tracked state by one aux byte and queue the word it causes
	task automatic track_byte(input logic [7:0] b);
		mouse_word_t w;
		int dx;
		int dy;
		w = '0;
		case (pkt_phase)
			ps2mt_pkg::PH_HEADER: begin
				// a header needs the sync bit and no overflow; drop anything else
				if (!b[ps2mt_pkg::HDR_SYNC] || b[ps2mt_pkg::HDR_XOVF]
						|| b[ps2mt_pkg::HDR_YOVF]) begin
					w.dropped = 1'b1;
					if (drop_count != '1)
						drop_count = drop_count + 1'b1;
				end else begin
					held_header = b;
					pkt_phase = ps2mt_pkg::PH_XDATA;
				end
			end
			ps2mt_pkg::PH_XDATA: begin
				held_x_byte = b;
				pkt_phase = ps2mt_pkg::PH_YDATA;
			end
			default: begin
				dx = held_header[ps2mt_pkg::HDR_XOVF] ? 0
					: $signed({held_header[ps2mt_pkg::HDR_XSIGN], held_x_byte});
				dy = held_header[ps2mt_pkg::HDR_YOVF] ? 0
					: $signed({held_header[ps2mt_pkg::HDR_YSIGN], b});
				pkt_phase = ps2mt_pkg::PH_HEADER;
				w.done = 1'b1;
				// a move clamped back onto the same spot still counts as a change
				if (dx != 0 || dy != 0) begin
					track_x = clamp_axis(int'(track_x) + dx * int'(speed_scale));
					track_y = clamp_axis(int'(track_y) - dy * int'(speed_scale));
					w.changed = 1'b1;
				end
				if ({held_header[ps2mt_pkg::HDR_RIGHT], held_header[ps2mt_pkg::HDR_LEFT]}
						!= track_buttons) begin
					track_buttons = {held_header[ps2mt_pkg::HDR_RIGHT],
						held_header[ps2mt_pkg::HDR_LEFT]};
					w.changed = 1'b1;
				end
			end
		endcase
		w.pos_x = track_x;
		w.pos_y = track_y;
		w.buttons = track_buttons;
		w.drop_total = drop_count;
		pending_words.push_back(w);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_word(input logic [63:0] data, input logic [2:0] user);
		mouse_word_t w;
		if (pending_words.size() == 0) begin
			$error("output word with no byte waiting for it: tdata %h tuser %b", data, user);
			fail_count++;
		end else begin
			w = pending_words.pop_front();
			compare_field("pos_x", 64'(w.pos_x), 64'(data[14:0]));
			compare_field("pos_y", 64'(w.pos_y), 64'(data[29:15]));
			compare_field("button_bits", 64'(w.buttons), 64'(data[31:30]));
			compare_field("drop_total", 64'(w.drop_total), 64'(data[63:32]));
			compare_field("packet_done", 64'(w.done), 64'(user[0]));
			compare_field("state_changed", 64'(w.changed), 64'(user[1]));
			compare_field("byte_dropped", 64'(w.dropped), 64'(user[2]));
		end
	endtask

	// predict and check on the edge where the words move; watch for a hang
	always @(posedge clk) begin
		if (speed_take)
			apply_speed(speed_seen);
		if (byte_take)
			track_byte(byte_seen);
		if (word_take)
			check_word(word_data, word_user);
		if (byte_take || word_take)
			hang_cycles = 0;
		else
			hang_cycles++;
		if (hang_cycles >= HANG_LIMIT) begin
			$display("ps2_mouse_packet_tracker verification failed");
			$finish;
		end
	end

	// offer one byte, idling first at the current rate; return on the accepting edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(negedge clk);
		while (s_tready !== 1'b1);
		@(posedge clk);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
			input logic [7:0] yb);
		send_byte(hdr);
		send_byte(xb);
		send_byte(yb);
	endtask

	// hold the input until every queued word is out and the pipeline is empty
	task automatic drain_words();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_speed(input logic [SPW-1:0] v);
		drain_words();
		speed_we <= 1'b1;
		speed_wdata <= v;
		@(posedge clk);
		speed_we <= 1'b0;
	endtask

	// bad headers: sync bit clear, either overflow bit set, all ones, all zeros
	task automatic test_header_filter();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hF7);
		send_byte(8'hC8);
		send_byte(8'h48);
		send_byte(8'h88);
	endtask

	task automatic test_packets();
		send_packet(8'h08, 8'h00, 8'h00);   // no move, no button change
		send_packet(8'h0B, 8'h00, 8'h00);   // both buttons down
		send_packet(8'h09, 8'hFF, 8'hFF);   // largest positive move
		send_packet(8'h38, 8'h00, 8'h00);   // largest negative move
		send_packet(8'h2A, 8'hC8, 8'h08);   // data bytes that look like headers
	endtask

	// zero write is ignored, an oversize write saturates, then both ends of the range
	task automatic test_speed_register();
		set_speed('0);
		send_packet(8'h08, 8'h01, 8'h01);
		set_speed('1);
		send_packet(8'h08, 8'hFF, 8'hFF);
		send_packet(8'h08, 8'hFF, 8'hFF);   // already at the edge: clamped again
		set_speed(10'd1);
		send_packet(8'h38, 8'h00, 8'h00);
		set_speed(ps2mt_pkg::SPEED_LIMIT);
		send_packet(8'h3B, 8'h00, 8'h00);
	endtask

	// mostly framed packets with random content, the rest stray bytes
	task automatic test_random_traffic(input bit with_pause);
		int sent;
		logic [7:0] r;
		sent = 0;
		set_speed(SPW'($urandom_range(1) ? $urandom_range(1, 32) : $urandom_range(0, 1023)));
		while (sent < RANDOM_WORDS) begin
			if (with_pause && sent >= RANDOM_WORDS / 2 && sent < RANDOM_WORDS / 2 + 3)
				drain_words();
			if (sent >= RANDOM_WORDS / 3 && sent < RANDOM_WORDS / 3 + 3)
				set_speed(SPW'($urandom_range(0, 1023)));
			if ($urandom_range(99) < 80) begin
				r = 8'($urandom_range(255));
				send_packet({2'b00, r[5:4], 1'b1, r[2:0]}, 8'($urandom_range(255)),
					8'($urandom_range(255)));
				sent += 3;
			end else begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_filter();
		test_packets();
		test_speed_register();

		test_random_traffic(1'b1);
		send_idle_pct = 68;
		recv_idle_pct = 36;
		test_random_traffic(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(1'b0);

		drain_words();
		if (fail_count == 0 && pending_words.size() == 0)
			$display("ps2_mouse_packet_tracker verification clean");
		else
			$display("ps2_mouse_packet_tracker verification failed");
		$finish;
	end

endmodule
